// ===== rtl/core/rrs_pkg.sv =====
// Shared constants, codes, state type and control structs of the row ring store.
package rrs_pkg;

  localparam int DATA_BYTES = 65536;
  localparam int ROW_SLOTS  = 4096;
  localparam int ADDR_W     = $clog2(DATA_BYTES);
  localparam int SLOT_W     = $clog2(ROW_SLOTS);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int LEN_W      = 17;
  localparam int ENT_W      = ADDR_W + LEN_W + 1;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LONG  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [LEN_W-1:0] STORE_BYTES_RESET = 17'd65536;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_EV_CHECK,
    S_EV_DROP,
    S_COMMIT,
    S_RD_ENT,
    S_RD_BYTE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic cfg_wr;
    logic clear;
    logic reject;
    logic drop;
    logic commit;
    logic cont_byte;
    logic ent_sel;
    logic res_nf;
    logic res_zero;
    logic res_read;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       first;
    logic       too_long;
    logic       need_drop;
    logic       row_oob;
    logic       byte_oob;
  } sts_t;

endpackage

// ===== rtl/core/rrs_if.sv =====
// Channel interfaces of the row ring store: input items, results and configuration.
interface rrs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [16:0] row_length;
  logic        first_of_row;
  logic        continuation;
  logic [7:0]  data_byte;
  logic [11:0] row_select;
  logic [15:0] byte_offset;
  modport source (output valid, op, row_length, first_of_row, continuation, data_byte,
                  row_select, byte_offset, input ready);
  modport sink (input valid, op, row_length, first_of_row, continuation, data_byte,
                row_select, byte_offset, output ready);
endinterface

interface rrs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        row_done;
  logic [31:0] row_number;
  logic [7:0]  read_byte;
  logic [16:0] read_length;
  logic        read_continuation;
  logic [12:0] rows_held;
  logic [16:0] bytes_held;
  modport source (output valid, status, row_done, row_number, read_byte, read_length,
                  read_continuation, rows_held, bytes_held, input ready);
  modport sink (input valid, status, row_done, row_number, read_byte, read_length,
                read_continuation, rows_held, bytes_held, output ready);
endinterface

interface rrs_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/rrs_ctrl.sv =====
// Controller state machine of the row ring store.
module rrs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          out_ready,
  output logic          out_valid,
  output rrs_pkg::cmd_t cmd,
  input  rrs_pkg::sts_t sts
);
  import rrs_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        unique case (sts.op)
          OP_APPEND: begin
            if (sts.first && !sts.too_long) state_next = S_EV_CHECK;
            else state_next = S_FINISH;
          end
          OP_READ: begin
            if (sts.row_oob) state_next = S_FINISH;
            else state_next = S_RD_ENT;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_EV_CHECK: begin
        if (sts.need_drop) state_next = S_EV_DROP;
        else state_next = S_COMMIT;
      end
      S_EV_DROP: state_next = S_EV_CHECK;
      S_COMMIT:  state_next = S_FINISH;
      S_RD_ENT: begin
        if (sts.byte_oob) state_next = S_FINISH;
        else state_next = S_RD_BYTE;
      end
      S_RD_BYTE: state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
        cmd.cfg_wr  = cfg_valid;
      end
      S_EXEC: begin
        cmd.ent_sel = 1'b1;
        unique case (sts.op)
          OP_APPEND: begin
            if (sts.first) cmd.reject = sts.too_long;
            else cmd.cont_byte = 1'b1;
          end
          OP_READ:  cmd.res_nf = sts.row_oob;
          OP_CLEAR: begin
            cmd.clear    = 1'b1;
            cmd.res_zero = 1'b1;
          end
          default: cmd.res_zero = 1'b1;
        endcase
      end
      S_EV_CHECK: cmd.ent_sel = 1'b0;
      S_EV_DROP:  cmd.drop = 1'b1;
      S_COMMIT:   cmd.commit = 1'b1;
      S_RD_ENT: begin
        cmd.ent_sel = 1'b1;
        cmd.res_nf  = sts.byte_oob;
      end
      S_RD_BYTE: begin
        cmd.ent_sel  = 1'b1;
        cmd.res_read = 1'b1;
      end
      S_FINISH: cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/rrs_datapath.sv =====
// Datapath of the row ring store: byte store, row index, counters and result registers.
module rrs_datapath (
  input  logic          clk,
  input  logic          rst,
  input  rrs_pkg::cmd_t cmd,
  output rrs_pkg::sts_t sts,
  input  logic [16:0]   cfg_data,
  input  logic [1:0]    op,
  input  logic [16:0]   row_length,
  input  logic          first_of_row,
  input  logic          continuation,
  input  logic [7:0]    data_byte,
  input  logic [11:0]   row_select,
  input  logic [15:0]   byte_offset,
  output logic [1:0]    status,
  output logic          row_done,
  output logic [31:0]   row_number,
  output logic [7:0]    read_byte,
  output logic [16:0]   read_length,
  output logic          read_continuation,
  output logic [12:0]   rows_held,
  output logic [16:0]   bytes_held
);
  import rrs_pkg::*;

  logic [7:0]       byte_mem [DATA_BYTES];
  logic [ENT_W-1:0] ent_mem [ROW_SLOTS];

  logic [LEN_W-1:0]  store_bytes;
  logic [31:0]       oldest_seq;
  logic [31:0]       next_seq;
  logic [CNT_W-1:0]  count_rows;
  logic [LEN_W-1:0]  used_bytes;
  logic [ADDR_W-1:0] write_pos;
  logic [LEN_W-1:0]  bytes_remaining;
  logic              dropping_row;
  logic [ADDR_W-1:0] cur_pos;

  logic [1:0]        it_op;
  logic [LEN_W-1:0]  it_len;
  logic              it_first;
  logic              it_cont;
  logic [7:0]        it_data;
  logic [11:0]       it_ridx;
  logic [15:0]       it_boff;

  logic [ENT_W-1:0]  ent_q;
  logic [7:0]        byte_q;

  logic [1:0]        res_status;
  logic              res_done;
  logic [31:0]       res_number;
  logic [7:0]        res_byte;
  logic [LEN_W-1:0]  res_len;
  logic              res_cont;
  logic              res_set;

  logic [LEN_W-1:0]  cap;
  logic [SLOT_W-1:0] ent_raddr;
  logic [ADDR_W-1:0] q_off;
  logic [LEN_W-1:0]  q_len;
  logic              q_flag;
  logic [LEN_W-1:0]  rd_sum;
  logic [ADDR_W-1:0] rd_pos;
  logic [LEN_W-1:0]  wp_sum;
  logic [ADDR_W-1:0] wp_next;
  logic [ADDR_W-1:0] wp_inc;
  logic [ADDR_W-1:0] cur_inc;
  logic [LEN_W:0]    used_sum;
  logic              bw_en;
  logic [ADDR_W-1:0] bw_addr;

  always_comb begin
    if (store_bytes == '0) cap = LEN_W'(1);
    else if (store_bytes > LEN_W'(DATA_BYTES)) cap = LEN_W'(DATA_BYTES);
    else cap = store_bytes;
  end

  assign ent_raddr = cmd.ent_sel ? SLOT_W'(oldest_seq + 32'(it_ridx)) : SLOT_W'(oldest_seq);
  assign q_off  = ent_q[ENT_W-1 -: ADDR_W];
  assign q_len  = ent_q[LEN_W:1];
  assign q_flag = ent_q[0];

  assign rd_sum  = LEN_W'(q_off) + LEN_W'(it_boff);
  assign rd_pos  = (rd_sum >= cap) ? ADDR_W'(rd_sum - cap) : ADDR_W'(rd_sum);
  assign wp_sum  = LEN_W'(write_pos) + it_len;
  assign wp_next = (wp_sum >= cap) ? ADDR_W'(wp_sum - cap) : ADDR_W'(wp_sum);
  assign wp_inc  = ((LEN_W'(write_pos) + LEN_W'(1)) >= cap) ? '0 : write_pos + 1'b1;
  assign cur_inc = ((LEN_W'(cur_pos) + LEN_W'(1)) >= cap) ? '0 : cur_pos + 1'b1;
  assign used_sum = {1'b0, used_bytes} + {1'b0, it_len};

  assign sts.op        = it_op;
  assign sts.first     = it_first;
  assign sts.too_long  = it_len > cap;
  assign sts.need_drop = ((count_rows != '0) && (used_sum > {1'b0, cap}))
                         || (count_rows == CNT_W'(ROW_SLOTS));
  assign sts.row_oob   = CNT_W'(it_ridx) >= count_rows;
  assign sts.byte_oob  = (q_len == '0) || (LEN_W'(it_boff) >= q_len);

  always_comb begin
    bw_en   = 1'b0;
    bw_addr = cur_pos;
    if (cmd.commit) begin
      bw_en   = it_len != '0;
      bw_addr = write_pos;
    end else if (cmd.cont_byte) begin
      bw_en = !dropping_row && (bytes_remaining != '0);
    end
  end

  assign res_set = cmd.reject | cmd.commit | cmd.cont_byte | cmd.res_nf | cmd.res_zero
                   | cmd.res_read;

  always_ff @(posedge clk) begin
    if (bw_en) byte_mem[bw_addr] <= it_data;
    byte_q <= byte_mem[rd_pos];
    if (cmd.commit) ent_mem[SLOT_W'(next_seq)] <= {write_pos, it_len, it_cont};
    ent_q <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_op    <= op;
      it_len   <= row_length;
      it_first <= first_of_row;
      it_cont  <= continuation;
      it_data  <= data_byte;
      it_ridx  <= row_select;
      it_boff  <= byte_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store_bytes     <= STORE_BYTES_RESET;
      oldest_seq      <= '0;
      next_seq        <= '0;
      count_rows      <= '0;
      used_bytes      <= '0;
      write_pos       <= '0;
      bytes_remaining <= '0;
      dropping_row    <= 1'b0;
    end else begin
      if (cmd.cfg_wr) store_bytes <= cfg_data;
      if (cmd.cfg_wr || cmd.clear) begin
        oldest_seq      <= '0;
        next_seq        <= '0;
        count_rows      <= '0;
        used_bytes      <= '0;
        write_pos       <= '0;
        bytes_remaining <= '0;
        dropping_row    <= 1'b0;
      end else if (cmd.reject) begin
        dropping_row    <= 1'b1;
        bytes_remaining <= '0;
      end else if (cmd.drop) begin
        used_bytes <= (q_len > used_bytes) ? '0 : used_bytes - q_len;
        oldest_seq <= oldest_seq + 32'd1;
        count_rows <= count_rows - 1'b1;
      end else if (cmd.commit) begin
        dropping_row    <= 1'b0;
        write_pos       <= wp_next;
        used_bytes      <= LEN_W'(used_sum);
        next_seq        <= next_seq + 32'd1;
        count_rows      <= count_rows + 1'b1;
        bytes_remaining <= (it_len == '0) ? '0 : it_len - 1'b1;
        cur_pos         <= wp_inc;
      end else if (cmd.cont_byte && bw_en) begin
        bytes_remaining <= bytes_remaining - 1'b1;
        cur_pos         <= cur_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_set) begin
      res_status <= ST_OK;
      res_done   <= 1'b0;
      res_number <= '0;
      res_byte   <= '0;
      res_len    <= '0;
      res_cont   <= 1'b0;
      if (cmd.reject) res_status <= ST_TOO_LONG;
      if (cmd.res_nf) res_status <= ST_NOT_FOUND;
      if (cmd.commit && (it_len <= LEN_W'(1))) begin
        res_done   <= 1'b1;
        res_number <= next_seq;
      end
      if (cmd.cont_byte) begin
        if (dropping_row) begin
          res_status <= ST_TOO_LONG;
        end else if (bytes_remaining == LEN_W'(1)) begin
          res_done   <= 1'b1;
          res_number <= next_seq - 32'd1;
        end
      end
      if (cmd.res_read) begin
        res_byte <= byte_q;
        res_len  <= q_len;
        res_cont <= q_flag;
      end
    end
    if (cmd.load_out) begin
      status            <= res_status;
      row_done          <= res_done;
      row_number        <= res_number;
      read_byte         <= res_byte;
      read_length       <= res_len;
      read_continuation <= res_cont;
      rows_held         <= 13'(count_rows);
      bytes_held        <= used_bytes;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_rows <= CNT_W'(ROW_SLOTS))
    else $error("row count exceeds index slots");
  a_wp_bound: assert property (@(posedge clk) disable iff (rst)
    LEN_W'(write_pos) < cap)
    else $error("write position outside capacity");
  a_empty_used: assert property (@(posedge clk) disable iff (rst)
    (count_rows == '0) |-> (used_bytes == '0))
    else $error("bytes held with no rows");
  a_drop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.drop |-> (count_rows != '0))
    else $error("eviction from an empty index");
`endif

endmodule

// ===== rtl/core/row_ring_store_with_eviction.sv =====
// Top level of the row ring store with oldest-first eviction.
//
//  Channel | Role | Handshake   | Payload
//  cfg     | sink | valid/ready | data: store_bytes
//  in      | sink | valid/ready | op, row_length, first_of_row, continuation, data_byte,
//          |      |             | row_select, byte_offset
//  out     | src  | valid/ready | status, row_done, row_number, read_byte, read_length,
//          |      |             | read_continuation, rows_held, bytes_held
//
// One transaction is handled at a time: a clear, a rejected row or a continuing byte
// goes from execute to finish; a read passes the index and byte read states, ending
// early when the row or byte is not found; the first byte of a row checks for eviction,
// drops oldest rows one at a time, then commits; each eviction waits on the registered
// read of the index memory. Reset restores a capacity of 65536 bytes and empties the store; no clearing pass.
// A new transaction is taken while the previous result waits on a stalled output.
module row_ring_store_with_eviction (
  input logic      clk,
  input logic      rst,
  rrs_cfg_if.sink  cfg,
  rrs_in_if.sink   in,
  rrs_out_if.source out
);
  import rrs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in.valid),
    .in_ready  (in.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .out_ready (out.ready),
    .out_valid (out.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  rrs_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_data          (cfg.data),
    .op                (in.op),
    .row_length        (in.row_length),
    .first_of_row      (in.first_of_row),
    .continuation      (in.continuation),
    .data_byte         (in.data_byte),
    .row_select        (in.row_select),
    .byte_offset       (in.byte_offset),
    .status            (out.status),
    .row_done          (out.row_done),
    .row_number        (out.row_number),
    .read_byte         (out.read_byte),
    .read_length       (out.read_length),
    .read_continuation (out.read_continuation),
    .rows_held         (out.rows_held),
    .bytes_held        (out.bytes_held)
  );

endmodule
